FILE: src/assert_macros.svh
// Assertion macros shared by the nearest point filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define NPT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check a property on every clock edge, reset included.
`define NPT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

FILE: src/npt_pkg.sv
// Package: types, constants and width helpers of the nearest point filter.
`default_nettype none
package npt_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 16;

	localparam int IDX_W  = 10;
	localparam int DIST_W = 33;

	localparam logic [DIST_W-1:0] THRESH_RESET = 33'd262144;

	localparam logic REG_THRESH = 1'b0;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_QUERY = 2'd2
	} mode_t;

	typedef struct packed {
		logic start;
		logic issue;
	} scan_ctl_t;

	function automatic int dist_width(input int coord_bits);
		int sum_w;
		sum_w = 2 * (coord_bits + 1) + 1;
		return (sum_w > 64) ? 64 : sum_w;
	endfunction

endpackage
`default_nettype wire

FILE: src/npt_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module npt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: src/npt_scan.sv
// Distance pipeline and running minimum tracker for one query scan.
`default_nettype none
module npt_scan
	import npt_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int IDX_BITS   = 10,
	localparam int DW        = dist_width(COORD_BITS)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire scan_ctl_t               ctl,
	input  wire logic [IDX_BITS-1:0]     issue_idx,
	input  wire logic [2*COORD_BITS-1:0] rdata,
	input  wire logic [COORD_BITS-1:0]   qx,
	input  wire logic [COORD_BITS-1:0]   qy,
	output logic      [IDX_BITS-1:0]     best_idx,
	output logic      [DW-1:0]           best_d,
	output logic                         busy
);

	localparam int CB    = COORD_BITS;
	localparam int MW    = CB + 1;
	localparam int SQ_W  = 2 * MW;
	localparam int SUM_W = SQ_W + 1;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic [IDX_BITS-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [MW-1:0]       magx_s2, magy_s2;
	logic [SQ_W-1:0]     sqx_s3, sqy_s3;
	logic [DW-1:0]       d_s4;
	logic                first_q;
	logic [IDX_BITS-1:0] best_idx_q;
	logic [DW-1:0]       best_d_q;

	logic [MW-1:0]    dx, dy, magx, magy;
	logic [SUM_W-1:0] sum;
	logic [DW-1:0]    dsat;

	always_comb begin
		dx = {qx[CB-1], qx} - {rdata[CB-1], rdata[CB-1:0]};
		dy = {qy[CB-1], qy} - {rdata[2*CB-1], rdata[2*CB-1:CB]};
		magx = dx[MW-1] ? (~dx + MW'(1)) : dx;
		magy = dy[MW-1] ? (~dy + MW'(1)) : dy;
		sum = SUM_W'(sqx_s3) + SUM_W'(sqy_s3);
		if (SUM_W > DW && (sum >> DW) != '0)
			dsat = '1;
		else
			dsat = DW'(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			first_q <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (ctl.start)
				first_q <= 1'b1;
			else if (v_s4)
				first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= issue_idx;
		idx_s2  <= idx_s1;
		idx_s3  <= idx_s2;
		idx_s4  <= idx_s3;
		magx_s2 <= magx;
		magy_s2 <= magy;
		sqx_s3  <= magx_s2 * magx_s2;
		sqy_s3  <= magy_s2 * magy_s2;
		d_s4    <= dsat;
		if (v_s4 && (first_q || d_s4 < best_d_q)) begin
			best_d_q   <= d_s4;
			best_idx_q <= idx_s4;
		end
	end

	assign best_idx = best_idx_q;
	assign best_d   = best_d_q;
	assign busy     = v_s1 | v_s2 | v_s3 | v_s4;

`include "assert_macros.svh"

	`NPT_ASSERT(a_start_idle, ctl.start |-> !busy, "query started with scan beats in flight")
	`NPT_ASSERT(a_best_falls, v_s4 && !first_q |=> best_d_q <= $past(best_d_q), "minimum rose")

endmodule
`default_nettype wire

FILE: src/nearest_point_threshold_filter.sv
// Top level: obstacle point store with nearest point query and threshold test.
//
//  channel | dir | beat contents
//  s_*     | in  | tdata: point_x[15:0], point_y[31:16]; tuser: mode
//  m_*     | out | tdata: nearest_index, nearest_dist_sq, is_near; tuser: empty, ovf
//  apb     | in  | threshold register at byte address 0, 64-bit data
//
// Clear and load beats are taken while idle and leave the block idle.
// A query makes one RAM read per stored point and then drains the read,
// distance and compare pipeline; an empty store goes straight to the result.
// Reset clears count and overflow flag and restores the threshold; the store needs no clearing.
// A result held on m_* stalls only the end of the next query.
`default_nettype none
module nearest_point_threshold_filter
	import npt_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // point_x[15:0], point_y[31:16]
	input  wire logic [1:0]  s_tuser,  // mode[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata,  // nearest_index[9:0], nearest_dist_sq[42:10], is_near[43]
	output logic      [1:0]  m_tuser,  // store_empty[0], store_overflowed[1]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready
);

	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int CB   = COORD_BITS;
	localparam int DW   = dist_width(COORD_BITS);
	localparam int CMPW = (DW > DIST_W) ? DW : DIST_W;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rd_q;
	logic              ovf_q;
	logic              empty_q;
	logic [DIST_W-1:0] thresh_q;
	logic [CB-1:0]     qx_q, qy_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_near_q;
	logic              out_empty_q;
	logic              out_ovf_q;

	logic              in_acc;
	mode_t             in_mode;
	logic [CB-1:0]     in_x, in_y;
	logic              full;
	logic              issue;
	logic              ram_we;
	logic              out_load;
	logic              cfg_wr;
	logic [2*CB-1:0]   rdata;
	logic [AW-1:0]     best_idx;
	logic [DW-1:0]     best_d;
	logic              busy;
	scan_ctl_t         ctl;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_mode  = mode_t'(s_tuser);
	assign in_x     = CB'(s_tdata[15:0]);
	assign in_y     = CB'(s_tdata[31:16]);
	assign full     = (count_q == CW'(MAX_POINTS));
	assign ram_we   = in_acc && in_mode == MODE_LOAD && !full;
	assign issue    = (state_q == ST_SCAN) && (rd_q != count_q);
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_tready);
	assign cfg_wr   = psel && penable && pwrite && pready && paddr[3] == REG_THRESH;

	assign ctl.start = in_acc && in_mode == MODE_QUERY;
	assign ctl.issue = issue;

	npt_ram #(
		.WIDTH(2 * CB),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata({in_y, in_x}),
		.re   (issue),
		.raddr(rd_q[AW-1:0]),
		.rdata(rdata)
	);

	npt_scan #(
		.COORD_BITS(CB),
		.IDX_BITS  (AW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.issue_idx(rd_q[AW-1:0]),
		.rdata    (rdata),
		.qx       (qx_q),
		.qy       (qy_q),
		.best_idx (best_idx),
		.best_d   (best_d),
		.busy     (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_q        <= '0;
			ovf_q       <= 1'b0;
			empty_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (in_mode)
							MODE_CLEAR: begin
								count_q <= '0;
								ovf_q   <= 1'b0;
							end
							MODE_LOAD: begin
								if (full)
									ovf_q <= 1'b1;
								else
									count_q <= count_q + CW'(1);
							end
							MODE_QUERY: begin
								rd_q    <= '0;
								empty_q <= (count_q == '0);
								state_q <= (count_q == '0) ? ST_FIN : ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue)
						rd_q <= rd_q + CW'(1);
					else if (!busy)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			qx_q <= in_x;
			qy_q <= in_y;
		end
		if (out_load) begin
			out_idx_q   <= empty_q ? '0 : IDX_W'(best_idx);
			out_dist_q  <= empty_q ? '0 : DIST_W'(best_d);
			out_near_q  <= !empty_q && (CMPW'(best_d) < CMPW'(thresh_q));
			out_empty_q <= empty_q;
			out_ovf_q   <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thresh_q <= THRESH_RESET;
		else if (cfg_wr)
			thresh_q <= pwdata[DIST_W-1:0];
	end

	assign pready   = 1'b1;
	assign prdata   = (paddr[3] == REG_THRESH) ? 64'(thresh_q) : '0;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_near_q, out_dist_q, out_idx_q};
	assign m_tuser  = {out_ovf_q, out_empty_q};

`include "assert_macros.svh"

	`NPT_ASSERT(a_count_max, count_q <= CW'(MAX_POINTS), "point count past store depth")
	`NPT_ASSERT(a_full_ovf, ram_we |-> !full, "write into a full store")
	`NPT_ASSERT(a_drop_flag, in_acc && in_mode == MODE_LOAD && full |=> ovf_q, "dropped load not flagged")
	`NPT_ASSERT(a_empty_zero, out_valid_q && out_empty_q |-> out_dist_q == '0 && !out_near_q, "empty result not zero")

endmodule
`default_nettype wire
